// ===== hdl/rcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types, constants and width helpers for the row cluster placement unit.
// ----------------------------------------------------------------------------
package rcp_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 32;

   localparam int BLOCK_WIDTH_W = 10;
   localparam int LOCATION_W    = 16;
   localparam int BOUND_W       = 16;
   localparam int LEFT_W        = 18;

   localparam int BLOCK_WIDTH_MAX = 1023;
   localparam int LOCATION_RANGE  = 65536;

   // Configuration space.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_LOWER = 1'b0;
   localparam logic CSR_IDX_UPPER = 1'b1;
   localparam logic [BOUND_W-1:0] ROW_HI_RESET = 16'hFFFF;

   typedef struct packed {
      logic [BLOCK_WIDTH_W-1:0] block_width;
      logic [LOCATION_W-1:0]    desired_location;
      logic                     last_block;
   } req_type;

   typedef struct packed {
      logic signed [LEFT_W-1:0] block_left;
      logic                     is_last;
      logic                     overflow;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic clamp_lo;
      logic clamp_hi;
      logic emit;
      logic clear;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
      logic emit_last;
   } ctrl_sts_type;

   // Signed width that holds any anchor sum of a full cluster.
   function automatic int anchor_width(input int max_blocks);
      anchor_width = $clog2(max_blocks * (LOCATION_RANGE + max_blocks * BLOCK_WIDTH_MAX)) + 1;
   endfunction

   // Width of the divider numerator, which also holds the rounded quotient.
   function automatic int num_width(input int max_blocks);
      num_width = anchor_width(max_blocks) + 1;
   endfunction

endpackage

// ===== hdl/rcp_csr.sv =====
// ----------------------------------------------------------------------------
// rcp_csr
// APB-style register block holding the row segment bounds.
// ----------------------------------------------------------------------------
module rcp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rcp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rcp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [rcp_pkg::BOUND_W-1:0]       row_lo,
   output logic [rcp_pkg::BOUND_W-1:0]       row_hi
);
   import rcp_pkg::*;

   logic [BOUND_W-1:0] lower_ff;
   logic [BOUND_W-1:0] upper_ff;
   logic               wr_en;
   logic               reg_idx;

   // Registers sit on word boundaries; the byte offset bits are ignored.
   assign reg_idx = csr_paddr[2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= ROW_HI_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            CSR_IDX_LOWER: lower_ff <= csr_pwdata[BOUND_W-1:0];
            CSR_IDX_UPPER: upper_ff <= csr_pwdata[BOUND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_IDX_LOWER: csr_prdata = {{(CSR_DATA_W-BOUND_W){1'b0}}, lower_ff};
         CSR_IDX_UPPER: csr_prdata = {{(CSR_DATA_W-BOUND_W){1'b0}}, upper_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign row_lo     = lower_ff;
   assign row_hi     = upper_ff;

endmodule

// ===== hdl/rcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcp_ctrl
// Sequencer for loading, dividing, clamping and emitting one cluster.
// ----------------------------------------------------------------------------
module rcp_ctrl #(
   parameter int MAX_BLOCKS = rcp_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_last,
   output logic                       req_ready,
   input  rcp_pkg::ctrl_sts_type      sts,
   output rcp_pkg::ctrl_cmd_type      cmd
);
   import rcp_pkg::*;

   localparam int NUM_W = num_width(MAX_BLOCKS);
   localparam int DCNT_W = $clog2(NUM_W + 1);

   typedef enum logic [5:0] {
      ST_LOAD     = 6'b000001,
      ST_PREP     = 6'b000010,
      ST_DIVIDE   = 6'b000100,
      ST_CLAMP_LO = 6'b001000,
      ST_CLAMP_HI = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   always_comb begin
      state_in  = state_ff;
      dcnt_in   = dcnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            dcnt_in  = DCNT_W'(NUM_W);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff - 1'b1;
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = ST_CLAMP_LO;
            end
         end
         ST_CLAMP_LO: begin
            cmd.clamp_lo = 1'b1;
            state_in     = ST_CLAMP_HI;
         end
         ST_CLAMP_HI: begin
            cmd.clamp_hi = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule

// ===== hdl/rcp_dp.sv =====
// ----------------------------------------------------------------------------
// rcp_dp
// Cluster accumulators, width store, serial divider, clamp and result register.
// ----------------------------------------------------------------------------
module rcp_dp #(
   parameter int MAX_BLOCKS = rcp_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rcp_pkg::req_type            req_data,
   input  logic [rcp_pkg::BOUND_W-1:0] row_lo,
   input  logic [rcp_pkg::BOUND_W-1:0] row_hi,
   input  rcp_pkg::ctrl_cmd_type       cmd,
   output rcp_pkg::ctrl_sts_type       sts,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rcp_pkg::rsp_type            rsp_data
);
   import rcp_pkg::*;

   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W    = $clog2(MAX_BLOCKS);
   localparam int TW_W     = $clog2(MAX_BLOCKS * BLOCK_WIDTH_MAX + 1);
   localparam int ANCHOR_W = anchor_width(MAX_BLOCKS);
   localparam int NUM_W    = num_width(MAX_BLOCKS);
   localparam int DEN_W    = CNT_W + 1;
   localparam int POS_W    = NUM_W;

   logic [BLOCK_WIDTH_W-1:0] mem [MAX_BLOCKS];
   logic [BLOCK_WIDTH_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TW_W-1:0]          tw_ff, tw_in;
   logic signed [ANCHOR_W-1:0] sum_ff, sum_in;
   logic                     dropped_ff, dropped_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic signed [POS_W-1:0]  lx_ff, lx_in;
   logic [LEFT_W-1:0]        cur_ff, cur_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     full;
   logic                     wr_en;
   logic signed [ANCHOR_W-1:0] anchor;
   logic [ANCHOR_W-1:0]      abs_sum;
   logic [DEN_W-1:0]         den;
   logic [DEN_W:0]           trial;
   logic                     q_bit;
   logic signed [POS_W-1:0]  mean;
   logic signed [POS_W-1:0]  lower_s;
   logic signed [POS_W-1:0]  upper_s;
   logic signed [POS_W-1:0]  tw_s;
   logic signed [POS_W-1:0]  right_edge;
   logic signed [POS_W-1:0]  edge_final;
   logic                     emit_last;

   assign full    = (count_ff == CNT_W'(MAX_BLOCKS));
   assign wr_en   = cmd.load & ~full;
   assign anchor  = $signed(ANCHOR_W'(req_data.desired_location)) - $signed(ANCHOR_W'(tw_ff));
   assign abs_sum = sum_ff[ANCHOR_W-1] ? ANCHOR_W'(-sum_ff) : ANCHOR_W'(sum_ff);
   assign den     = {count_ff, 1'b0};
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit   = (trial >= {1'b0, den});

   assign mean       = neg_ff ? $signed(-num_ff) : $signed(num_ff);
   assign lower_s    = $signed(POS_W'(row_lo));
   assign upper_s    = $signed(POS_W'(row_hi));
   assign tw_s       = $signed(POS_W'(tw_ff));
   assign right_edge = lx_ff + tw_s;
   assign edge_final = (right_edge > upper_s) ? (upper_s - tw_s) : lx_ff;

   assign emit_last  = (CNT_W'(idx_ff) == (count_ff - 1'b1));

   always_comb begin
      count_in     = count_ff;
      tw_in        = tw_ff;
      sum_in       = sum_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      lx_in        = lx_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            tw_in    = tw_ff + TW_W'(req_data.block_width);
            sum_in   = sum_ff + anchor;
         end
      end

      // Rounded mean: floor((2|sum| + n) / 2n), sign restored afterwards.
      if (cmd.prep) begin
         neg_in = sum_ff[ANCHOR_W-1];
         num_in = {abs_sum, 1'b0} + NUM_W'(count_ff);
         rem_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = q_bit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], q_bit};
      end

      if (cmd.clamp_lo) begin
         lx_in = (mean < lower_s) ? lower_s : mean;
      end

      if (cmd.clamp_hi) begin
         cur_in = edge_final[LEFT_W-1:0];
      end

      if (cmd.emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.block_left = $signed(cur_ff);
         rsp_data_in.is_last    = emit_last;
         rsp_data_in.overflow   = dropped_ff;
         cur_in                 = cur_ff + LEFT_W'(rd_data_ff);
         idx_in                 = idx_ff + 1'b1;
      end

      if (cmd.clear) begin
         count_in   = '0;
         tw_in      = '0;
         sum_in     = '0;
         dropped_in = 1'b0;
         idx_in     = '0;
      end
   end

   // Width store: written while loading, read ahead at the next emit index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= req_data.block_width;
      end
      rd_data_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tw_ff        <= '0;
         sum_ff       <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         tw_ff        <= tw_in;
         sum_ff       <= sum_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      lx_ff       <= lx_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;
   assign sts.emit_last = emit_last;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

// ===== hdl/row_cluster_placement_unit.sv =====
// ----------------------------------------------------------------------------
// row_cluster_placement_unit
// Collapses one row cluster to its optimal left edge and emits packed positions.
// ----------------------------------------------------------------------------
// Blocks of a cluster arrive one word per cycle on the request channel, each
// carrying its width and desired left coordinate; the word with last_block set
// closes the cluster. While loading, the unit stores every width and sums the
// anchors (desired location less the widths loaded before it). After the last
// word it prepares the numerator and runs a bit-serial divider to form the
// mean anchor, rounded half away from zero, then clamps it first to the lower
// bound and then to the upper bound less the total width, the upper clamp
// taking precedence. It then emits one response word per stored block, in load
// order, one per cycle while the response side accepts them. Blocks beyond
// MAX_BLOCKS are discarded and every response word of that cluster carries
// the overflow flag. Requests are taken only while loading; the last response
// word sits in an output register, so loading of the next cluster starts
// while it waits. The row bounds live in an APB-style register block at byte
// addresses 0 (lower) and 4 (upper) and should be written only while the unit
// is idle.
// ----------------------------------------------------------------------------
module row_cluster_placement_unit #(
   parameter int MAX_BLOCKS = rcp_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rcp_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rcp_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rcp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rcp_pkg::*;

   logic [BOUND_W-1:0] row_lo;
   logic [BOUND_W-1:0] row_hi;
   ctrl_cmd_type       cmd;
   ctrl_sts_type       sts;

   // Bound registers.
   rcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .row_lo      (row_lo),
      .row_hi      (row_hi)
   );

   // The controller sequences load, divide, clamp and emit phases.
   rcp_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_block),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the cluster state, the width store and the divider.
   rcp_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .row_lo      (row_lo),
      .row_hi      (row_hi),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/tb_row_cluster_placement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_cluster_placement_unit
// Self-checking bench for the row cluster placement unit.
// ----------------------------------------------------------------------------
// Clusters of blocks are streamed into the request channel. A block model
// inside the bench collapses each cluster as it is accepted and queues the
// packed left positions due on the response channel. Each response word is
// compared field by field against the oldest position due. Both channels
// idle at random. The row bounds are rewritten between phases, while the
// unit is quiet. A watchdog ends the run if no word moves for too long.
// ----------------------------------------------------------------------------
module tb_row_cluster_placement_unit;

   import rcp_pkg::*;

   localparam int MAX_BLOCKS    = MAX_BLOCKS_DEFAULT;
   localparam int SETTLE_CYCLES = 40;    // prepare, divide and clamp, with margin
   localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on any channel
   localparam int PHASE_WORDS   = 3;     // minimum request words per random phase

   localparam logic [CSR_ADDR_W-1:0] LOWER_ADDR = {CSR_IDX_LOWER, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UPPER_ADDR = {CSR_IDX_UPPER, 2'b00};

   // Every input of the unit holds a known value from time zero.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Words waiting to be offered, and positions the unit still owes us.
   req_type block_queue[$];
   rsp_type due_lefts[$];

   // The bench's own copy of the row bounds and of the cluster being loaded.
   logic [BOUND_W-1:0]       row_lo = '0;
   logic [BOUND_W-1:0]       row_hi = ROW_HI_RESET;
   logic [BLOCK_WIDTH_W-1:0] stored_width[MAX_BLOCKS];
   int                       stored_count  = 0;
   longint                   width_total   = 0;
   longint                   anchor_total  = 0;
   logic                     blocks_dropped = 1'b0;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int send_gap       = 0;
   int ready_run      = 0;
   bit steady_flow    = 1'b0;

   always #6 clock = ~clock;

   row_cluster_placement_unit #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Mostly short gaps, now and then a long one; none at all in steady phases.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Widths lean on the extremes, zero included, but cover every bit pattern.
   function automatic int pick_width();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 0;
      if (roll == 1) return BLOCK_WIDTH_MAX;
      if (roll == 2) return 1;
      return $urandom_range(0, BLOCK_WIDTH_MAX);
   endfunction

   // Cluster sizes: mostly a handful of blocks, sometimes many, rarely overfull.
   function automatic int pick_cluster_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(1, 6);
      if (roll < 90) return $urandom_range(7, 20);
      if (roll < 97) return $urandom_range(21, MAX_BLOCKS);
      return $urandom_range(MAX_BLOCKS + 1, MAX_BLOCKS + 8);
   endfunction

   task automatic queue_block(input int width, input int location, input logic last);
      req_type item;
      item.block_width      = BLOCK_WIDTH_W'(width);
      item.desired_location = LOCATION_W'(location);
      item.last_block       = last;
      block_queue           = {block_queue, item};
   endtask

   // A cluster either has scattered desired locations or locations that sit
   // roughly abutted, as a legaliser would see them after a merge.
   task automatic queue_random_cluster(input int size);
      int width;
      int style;
      int base;
      int run;
      int loc;
      int k;
      style = $urandom_range(0, 2);
      base  = $urandom_range(0, LOCATION_RANGE - 1);
      run   = 0;
      for (k = 0; k < size; k++) begin
         width = pick_width();
         if (style == 0) begin
            loc = $urandom_range(0, LOCATION_RANGE - 1);
         end else begin
            loc = base + run + $urandom_range(0, 64) - 32;
         end
         if ($urandom_range(0, 15) == 0) loc = $urandom_range(0, 1) ? LOCATION_RANGE - 1 : 0;
         if (loc < 0) loc = 0;
         if (loc > LOCATION_RANGE - 1) loc = LOCATION_RANGE - 1;
         run += width;
         queue_block(width, loc, k == size - 1);
      end
   endtask

   function automatic void clear_cluster();
      stored_count   = 0;
      width_total    = 0;
      anchor_total   = 0;
      blocks_dropped = 1'b0;
   endfunction

   // Takes one accepted block into the cluster. On the last block it works out
   // the cluster's left edge and queues the packed position of each block.
   function automatic void place_block(input req_type blk);
      longint  left_pos;
      longint  twice_n;
      rsp_type word;
      int      k;
      if (stored_count < MAX_BLOCKS) begin
         anchor_total += longint'(blk.desired_location) - width_total;
         stored_width[stored_count] = blk.block_width;
         width_total += longint'(blk.block_width);
         stored_count++;
      end else begin
         blocks_dropped = 1'b1;
      end
      if (!blk.last_block) return;
      if (stored_count == 0) begin
         clear_cluster();
         return;
      end
      // Mean anchor, rounded half away from zero.
      twice_n = 2 * longint'(stored_count);
      if (anchor_total >= 0) begin
         left_pos = (2 * anchor_total + stored_count) / twice_n;
      end else begin
         left_pos = -((-2 * anchor_total + stored_count) / twice_n);
      end
      // Lower clamp first; the upper clamp is applied last and so wins.
      if (left_pos < longint'(row_lo)) left_pos = longint'(row_lo);
      if (left_pos + width_total > longint'(row_hi)) begin
         left_pos = longint'(row_hi) - width_total;
      end
      for (k = 0; k < stored_count; k++) begin
         word.block_left = LEFT_W'(left_pos);
         word.is_last    = (k == stored_count - 1);
         word.overflow   = blocks_dropped;
         due_lefts       = {due_lefts, word};
         left_pos += longint'(stored_width[k]);
      end
      clear_cluster();
   endfunction

   function automatic void note_mismatch(input string what, input rsp_type want,
                                         input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected left %0d last %0b overflow %0b, got left %0d last %0b overflow %0b",
                  $realtime, what, want.block_left, want.is_last, want.overflow,
                  got.block_left, got.is_last, got.overflow);
      end
   endfunction

   // Request driver. A word stays on the bus untouched until it is taken; after
   // each acceptance the block model is updated and a fresh gap is drawn.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            place_block(req_data);
            send_gap = pick_gap();
         end
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && block_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= block_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
               if (send_gap != 0) send_gap--;
            end
         end
      end
   end

   // Response monitor. Checks every accepted word against the oldest position
   // due, and toggles ready in runs so that stalls land on emission slots at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_lefts.size() == 0) begin
               note_mismatch("unexpected word", '0, rsp_data);
            end else if (rsp_data.block_left !== due_lefts[0].block_left ||
                         rsp_data.is_last !== due_lefts[0].is_last ||
                         rsp_data.overflow !== due_lefts[0].overflow) begin
               note_mismatch("word mismatch", due_lefts.pop_front(), rsp_data);
            end else begin
               void'(due_lefts.pop_front());
            end
         end
         if (ready_run != 0) begin
            ready_run--;
         end else if (rsp_ready && !steady_flow) begin
            ready_run = pick_gap();
            if (ready_run != 0) begin
               rsp_ready <= 1'b0;
               ready_run--;
            end else begin
               ready_run = $urandom_range(0, 6);
            end
         end else begin
            rsp_ready <= 1'b1;
            ready_run = $urandom_range(0, 15);
         end
      end
   end

   // Watchdog: a long spell with no word moving means the unit has hung.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $realtime, idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Register write: a setup phase, then an access phase held until pready is seen.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [BOUND_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Waits until every word has been sent and every position has come back,
   // then lets the divider and clamp stages run dry before going on.
   task automatic wait_drained();
      do @(negedge clock);
      while (block_queue.size() != 0 || req_valid || due_lefts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                 phase;
      int                 phase_words;
      int                 size;
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed clusters under the reset bounds.
      // Widest block at the far right: the upper clamp pulls it back.
      queue_block(BLOCK_WIDTH_MAX, LOCATION_RANGE - 1, 1'b1);
      // A zero-width block on its own.
      queue_block(0, 0, 1'b1);
      // Anchors 0 and 1: the mean of one half rounds up.
      queue_block(1, 0, 1'b0);
      queue_block(1, 2, 1'b1);
      // Three blocks, the middle one of zero width.
      queue_block(512, 100, 1'b0);
      queue_block(0, 100, 1'b0);
      queue_block(341, 101, 1'b1);
      // Negative mean anchor, raised to the lower bound.
      queue_block(BLOCK_WIDTH_MAX, 0, 1'b0);
      queue_block(BLOCK_WIDTH_MAX, 0, 1'b1);
      // Alternating bit patterns in both fields.
      queue_block('h2AA, 'hAAAA, 1'b0);
      queue_block('h155, 'h5555, 1'b1);
      // Three wide blocks all wanting the right end of the row.
      queue_block(BLOCK_WIDTH_MAX, LOCATION_RANGE - 1, 1'b0);
      queue_block(BLOCK_WIDTH_MAX, LOCATION_RANGE - 1, 1'b0);
      queue_block(BLOCK_WIDTH_MAX, LOCATION_RANGE - 1, 1'b1);
      wait_drained();

      // Random phases, each under its own pair of bounds, extremes first.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin lo = '0;   hi = '1; end
            1: begin lo = '1;   hi = '1; end
            2: begin lo = '0;   hi = '0; end
            3: begin lo = '1;   hi = '0; end
            4: begin
               lo = BOUND_W'($urandom_range(0, 30000));
               hi = lo + BOUND_W'($urandom_range(0, 35535));
            end
            default: begin
               lo = BOUND_W'($urandom_range(0, LOCATION_RANGE - 1));
               hi = BOUND_W'($urandom_range(0, LOCATION_RANGE - 1));
            end
         endcase
         write_csr(LOWER_ADDR, lo);
         write_csr(UPPER_ADDR, hi);
         row_lo = lo;
         row_hi = hi;
         steady_flow = (phase == 3);
         @(negedge clock);
         // The first phase fills the block store exactly; the second overfills
         // it so that trailing blocks, the last one among them, are dropped.
         if (phase == 0) begin
            queue_random_cluster(MAX_BLOCKS);
         end else if (phase == 1) begin
            queue_random_cluster(MAX_BLOCKS + 2);
         end else begin
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
               size = pick_cluster_size();
               queue_random_cluster(size);
               phase_words += size;
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0 && due_lefts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
